// File: hdl/lsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsa_pkg;

  // Operation codes of the func field; codes 12 to 15 are unused
  typedef enum logic [3:0] {
    FN_LBU = 4'd0,
    FN_LHU = 4'd1,
    FN_LW  = 4'd2,
    FN_LB  = 4'd3,
    FN_LH  = 4'd4,
    FN_SB  = 4'd5,
    FN_SH  = 4'd6,
    FN_SW  = 4'd7,
    FN_LWL = 4'd8,
    FN_LWR = 4'd9,
    FN_SWL = 4'd10,
    FN_SWR = 4'd11
  } func_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 5;
  localparam int unsigned WaddrW = 30;
  localparam logic [DataW-1:0] AllOnes = 32'hffff_ffff;

  // One access request
  typedef struct packed {
    logic [3:0]         func;
    logic [DataW-1:0]   addr;
    logic [DataW-1:0]   reg_value;
    logic [DataW-1:0]   mem_word;
    logic [RegIdxW-1:0] dest_reg;
  } lsa_req_t;

  // One access result
  typedef struct packed {
    logic [WaddrW-1:0]  word_addr;
    logic               mem_write;
    logic [3:0]         byte_enable;
    logic [DataW-1:0]   mem_data;
    logic               reg_write;
    logic [RegIdxW-1:0] reg_index;
    logic [DataW-1:0]   reg_data;
    logic               misaligned;
  } lsa_rsp_t;

endpackage

`default_nettype wire

// File: hdl/lsa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsa_req_if;
  logic              valid;
  logic              ready;
  lsa_pkg::lsa_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/lsa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsa_rsp_if;
  logic              valid;
  logic              ready;
  lsa_pkg::lsa_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/lsa_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline register slice: takes a beat whenever empty or draining
module lsa_stage #(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire T     in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output T          out_data_o
);

  logic valid_q, valid_d;
  T     data_q;

  // Accept when the held beat leaves or nothing is held
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on every accepted beat
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/lsa_align.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-lane alignment, extension and merge for one access
module lsa_align (
  input  wire lsa_pkg::lsa_req_t req_i,
  output lsa_pkg::lsa_rsp_t      rsp_o
);
  import lsa_pkg::*;

  logic [1:0]       lane;
  logic [4:0]       lo_sh;
  logic [4:0]       hi_sh;
  logic [DataW-1:0] mem_dn;
  logic [DataW-1:0] mem_up;
  logic [DataW-1:0] reg_dn;
  logic [DataW-1:0] reg_up;
  logic             half_mis;
  logic             word_mis;

  assign lane     = req_i.addr[1:0];
  assign lo_sh    = {lane, 3'b000};
  assign hi_sh    = {~lane, 3'b000};
  assign mem_dn   = req_i.mem_word >> lo_sh;
  assign mem_up   = req_i.mem_word << hi_sh;
  assign reg_dn   = req_i.reg_value >> hi_sh;
  assign reg_up   = req_i.reg_value << lo_sh;
  assign half_mis = lane[0];
  assign word_mis = (lane != 2'b00);

  // Decode the operation and build both write ports
  always_comb begin
    rsp_o             = '0;
    rsp_o.word_addr   = req_i.addr[DataW-1:2];
    rsp_o.reg_index   = req_i.dest_reg;
    case (req_i.func)
      FN_LBU: begin
        rsp_o.reg_write = 1'b1;
        rsp_o.reg_data  = {24'd0, mem_dn[7:0]};
      end
      FN_LB: begin
        rsp_o.reg_write = 1'b1;
        rsp_o.reg_data  = {{24{mem_dn[7]}}, mem_dn[7:0]};
      end
      FN_LHU: begin
        rsp_o.misaligned = half_mis;
        rsp_o.reg_write  = !half_mis;
        rsp_o.reg_data   = half_mis ? '0 : {16'd0, mem_dn[15:0]};
      end
      FN_LH: begin
        rsp_o.misaligned = half_mis;
        rsp_o.reg_write  = !half_mis;
        rsp_o.reg_data   = half_mis ? '0 : {{16{mem_dn[15]}}, mem_dn[15:0]};
      end
      FN_LW: begin
        rsp_o.misaligned = word_mis;
        rsp_o.reg_write  = !word_mis;
        rsp_o.reg_data   = word_mis ? '0 : req_i.mem_word;
      end
      FN_SB: begin
        rsp_o.mem_write   = 1'b1;
        rsp_o.mem_data    = {24'd0, req_i.reg_value[7:0]} << lo_sh;
        rsp_o.byte_enable = 4'b0001 << lane;
      end
      FN_SH: begin
        rsp_o.misaligned = half_mis;
        if (!half_mis) begin
          rsp_o.mem_write   = 1'b1;
          rsp_o.mem_data    = {16'd0, req_i.reg_value[15:0]} << lo_sh;
          rsp_o.byte_enable = 4'b0011 << lane;
        end
      end
      FN_SW: begin
        rsp_o.misaligned = word_mis;
        if (!word_mis) begin
          rsp_o.mem_write   = 1'b1;
          rsp_o.mem_data    = req_i.reg_value;
          rsp_o.byte_enable = 4'b1111;
        end
      end
      FN_LWL: begin
        rsp_o.reg_write = 1'b1;
        rsp_o.reg_data  = (req_i.reg_value & ~(AllOnes << hi_sh)) | mem_up;
      end
      FN_LWR: begin
        rsp_o.reg_write = 1'b1;
        rsp_o.reg_data  = (req_i.reg_value & ~(AllOnes >> lo_sh)) | mem_dn;
      end
      FN_SWL: begin
        rsp_o.mem_write   = 1'b1;
        rsp_o.mem_data    = (req_i.mem_word & ~(AllOnes >> hi_sh)) | reg_dn;
        rsp_o.byte_enable = 4'b1111;
      end
      FN_SWR: begin
        rsp_o.mem_write   = 1'b1;
        rsp_o.mem_data    = (req_i.mem_word & ~(AllOnes << lo_sh)) | reg_up;
        rsp_o.byte_enable = 4'b1111;
      end
      default: begin
        // unused codes write nothing
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mips32_load_store_align_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// req_i     in   func, addr, reg_value, mem_word, dest_reg
// rsp_o     out  word_addr, mem_write, byte_enable, mem_data, reg_write,
//                reg_index, reg_data, misaligned
//
// One beat per cycle sustained while rsp_o accepts; each taken request beat
// passes through the input register, then the result register.
// The alignment logic between the two registers is shifts, masks and muxes.
// A stall on rsp_o fills the result register and then the input register;
// req_i.ready drops only when both hold a beat.
// Reset clears both valid flags; payload registers are not reset.
module mips32_load_store_align_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lsa_req_if.sink   req_i,
  lsa_rsp_if.source rsp_o
);
  import lsa_pkg::*;

  logic     s1_valid;
  logic     s1_ready;
  lsa_req_t s1_req;
  lsa_rsp_t s1_rsp;

  // Register the incoming request
  lsa_stage #(.T(lsa_req_t)) u_req_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (req_i.payload),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_data_o  (s1_req)
  );

  // Align and merge
  lsa_align u_align (
    .req_i (s1_req),
    .rsp_o (s1_rsp)
  );

  // Register the result
  lsa_stage #(.T(lsa_rsp_t)) u_rsp_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_data_i   (s1_rsp),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp_o.payload)
  );

  // A flagged access writes nothing
  a_mis_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.misaligned |->
      !rsp_o.payload.mem_write && !rsp_o.payload.reg_write)
    else $error("misaligned result carries a write");

  // Memory and register writes exclude each other
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.payload.mem_write && rsp_o.payload.reg_write))
    else $error("result writes both memory and register");

  // Byte enables present exactly for memory writes
  a_be_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.payload.mem_write == (rsp_o.payload.byte_enable != 4'd0)))
    else $error("byte enables disagree with mem_write");

  // An accepted request beat is held in the input register next cycle
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_valid)
    else $error("accepted request lost");

endmodule

`default_nettype wire
